// File: src/ppop_pkg.sv
// Package for the polyline progress core: constants, transaction structs,
// divider lane type and sequencer codes. No dependencies.
package ppop_pkg;

   localparam int COORD_W     = 20;
   localparam int FRAC_W      = 16;
   localparam int SLOT_W      = 6;
   localparam int CNT_W       = 7;
   localparam int MAX_WP      = 64;
   localparam int MIN_WP      = 2;
   localparam int D_W         = COORD_W + 1;
   localparam int MUL_W       = 22;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int DD_W        = 2 * D_W;
   localparam int VD_W        = 2 * D_W + 1;
   localparam int E_W         = 39;
   localparam int EM_W        = E_W - 1;
   localparam int HALF_W      = EM_W / 2;
   localparam int DIST_W      = 76;
   localparam int T_W         = FRAC_W + 1;
   localparam int OP_W        = 4;
   localparam int SH_MID_AMT  = HALF_W + 1;
   localparam int SH_HIGH_AMT = 2 * HALF_W;

   localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_W;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic                      kind;
      logic [SLOT_W-1:0]         slot;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] segment_index;
      logic [T_W-1:0]    fraction;
      logic              too_few_points;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } wp_type;

   typedef struct packed {
      logic              valid;
      logic [DD_W-1:0]   rem;
      logic [DD_W-1:0]   dd;
      logic [FRAC_W-1:0] quo;
   } div_lane_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_FETCH, ST_DIFF, ST_DOT, ST_DIV, ST_TMUL, ST_ABS, ST_SQ, ST_CMP
   } state_type;

   typedef enum logic [2:0] {
      ACC_NONE, ACC_DD, ACC_VD, ACC_EX, ACC_EY, ACC_EZ, ACC_DIST
   } acc_type;

   typedef enum logic [1:0] {
      SH_NONE, SH_MID, SH_HIGH
   } shift_type;

   typedef struct packed {
      acc_type   dest;
      shift_type sh;
   } tag_type;

endpackage

// File: src/ppop_div_cell.sv
// One restoring-division cell: produces one quotient bit and passes the
// partial remainder to its neighbor. Depends on ppop_pkg.
module ppop_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  ppop_pkg::div_lane_type up_lane,
   output ppop_pkg::div_lane_type down_lane
);
   import ppop_pkg::*;

   div_lane_type    lane_ff;
   div_lane_type    lane_in;
   logic [DD_W:0]   shifted;
   logic            ge;

   always_comb begin
      shifted       = {up_lane.rem, 1'b0};
      ge            = shifted >= {1'b0, up_lane.dd};
      lane_in.valid = up_lane.valid;
      lane_in.dd    = up_lane.dd;
      lane_in.rem   = ge ? DD_W'(shifted - {1'b0, up_lane.dd}) : DD_W'(shifted);
      lane_in.quo   = {up_lane.quo[FRAC_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff <= '0;
      end else begin
         lane_ff <= lane_in;
      end
   end

   assign down_lane = lane_ff;

endmodule

// File: src/ppop_div_chain.sv
// Row of division cells, one quotient bit per cell.
// Depends on ppop_pkg and ppop_div_cell.
module ppop_div_chain (
   input  logic                   clock,
   input  logic                   reset,
   input  ppop_pkg::div_lane_type head,
   output ppop_pkg::div_lane_type tail
);
   import ppop_pkg::*;

   div_lane_type link [0:FRAC_W];

   assign link[0] = head;

   for (genvar g = 0; g < FRAC_W; g++) begin : g_cell
      ppop_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .up_lane   (link[g]),
         .down_lane (link[g+1])
      );
   end

   assign tail = link[FRAC_W];

endmodule

// File: src/polyline_progress_of_point_core.sv
// Closest-segment projection of a 3-D point onto a stored polyline.
// Queries with fewer than two waypoints return too_few_points; otherwise
// each segment is walked in turn, on the shared 22x22 multiplier and the
// 16-cell divider row. Throughput: one transaction at a time.
// Reset: synchronous, clears control and waypoint_count; table is unknown.
module polyline_progress_of_point_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ppop_pkg::req_type      req_data,
   output logic                   rsp_valid,
   output ppop_pkg::rsp_type      rsp_data,
   input  logic                   csr_we,
   input  logic [6:0]             csr_wdata
);
   import ppop_pkg::*;

   state_type                  state_ff, state_in;
   logic [OP_W-1:0]            op_cnt_ff, op_cnt_in;
   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           n_ff;
   logic [CNT_W-1:0]           n_start;
   logic [SLOT_W-1:0]          seg_ff;
   wp_type                     p_ff;
   wp_type                     mem [0:MAX_WP-1];
   wp_type                     rd_a_ff, rd_b_ff;
   logic signed [D_W-1:0]      d_ff [0:2];
   logic signed [D_W-1:0]      v_ff [0:2];
   logic [DD_W-1:0]            dd_ff;
   logic signed [VD_W-1:0]     vd_ff;
   logic [T_W-1:0]             t_ff;
   logic signed [E_W-1:0]      e_ff [0:2];
   logic [EM_W-1:0]            em_ff [0:2];
   logic [DIST_W-1:0]          dist_ff, best_dist_ff, sq_add;
   logic [SLOT_W-1:0]          best_seg_ff;
   logic [T_W-1:0]             best_t_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   tag_type                    tag_ff, tag_in;
   logic signed [MUL_W-1:0]    mul_a, mul_b;
   logic                       rsp_valid_ff;
   rsp_type                    rsp_ff;
   div_lane_type               div_head, div_tail;
   logic                       accept, zero_t, full_t, last_seg, take_cur;

   assign busy      = state_ff != ST_IDLE;
   assign accept    = start && !busy;
   assign n_start   = (count_ff > CNT_W'(MAX_WP)) ? CNT_W'(MAX_WP) : count_ff;
   assign zero_t    = (dd_ff == '0) || vd_ff[VD_W-1] || (vd_ff == '0);
   assign full_t    = $unsigned(vd_ff) >= {1'b0, dd_ff};
   assign last_seg  = (CNT_W'(seg_ff) + CNT_W'(MIN_WP)) == n_ff;
   assign take_cur  = (seg_ff == '0) || (dist_ff < best_dist_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   ppop_div_chain u_div (
      .clock (clock),
      .reset (reset),
      .head  (div_head),
      .tail  (div_tail)
   );

   always_comb begin
      state_in  = state_ff;
      op_cnt_in = op_cnt_ff;
      mul_a     = '0;
      mul_b     = '0;
      tag_in    = '{dest: ACC_NONE, sh: SH_NONE};
      div_head  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.kind == KIND_QUERY && n_start >= CNT_W'(MIN_WP)) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            state_in  = ST_DOT;
            op_cnt_in = '0;
         end
         ST_DOT: begin
            op_cnt_in = op_cnt_ff + 1'b1;
            unique case (op_cnt_ff)
               4'd0: begin mul_a = MUL_W'(d_ff[0]); mul_b = MUL_W'(d_ff[0]);
                  tag_in.dest = ACC_DD; end
               4'd1: begin mul_a = MUL_W'(d_ff[1]); mul_b = MUL_W'(d_ff[1]);
                  tag_in.dest = ACC_DD; end
               4'd2: begin mul_a = MUL_W'(d_ff[2]); mul_b = MUL_W'(d_ff[2]);
                  tag_in.dest = ACC_DD; end
               4'd3: begin mul_a = MUL_W'(v_ff[0]); mul_b = MUL_W'(d_ff[0]);
                  tag_in.dest = ACC_VD; end
               4'd4: begin mul_a = MUL_W'(v_ff[1]); mul_b = MUL_W'(d_ff[1]);
                  tag_in.dest = ACC_VD; end
               4'd5: begin mul_a = MUL_W'(v_ff[2]); mul_b = MUL_W'(d_ff[2]);
                  tag_in.dest = ACC_VD; end
               default: begin
                  state_in  = ST_DIV;
                  op_cnt_in = '0;
               end
            endcase
         end
         ST_DIV: begin
            if (op_cnt_ff == '0) begin
               if (zero_t || full_t) begin
                  state_in = ST_TMUL;
               end else begin
                  div_head.valid = 1'b1;
                  div_head.rem   = vd_ff[DD_W-1:0];
                  div_head.dd    = dd_ff;
                  op_cnt_in      = OP_W'(1);
               end
            end else if (div_tail.valid) begin
               state_in  = ST_TMUL;
               op_cnt_in = '0;
            end
         end
         ST_TMUL: begin
            op_cnt_in = op_cnt_ff + 1'b1;
            unique case (op_cnt_ff)
               4'd0: begin mul_a = MUL_W'(t_ff); mul_b = MUL_W'(d_ff[0]);
                  tag_in.dest = ACC_EX; end
               4'd1: begin mul_a = MUL_W'(t_ff); mul_b = MUL_W'(d_ff[1]);
                  tag_in.dest = ACC_EY; end
               4'd2: begin mul_a = MUL_W'(t_ff); mul_b = MUL_W'(d_ff[2]);
                  tag_in.dest = ACC_EZ; end
               default: begin
                  state_in  = ST_ABS;
                  op_cnt_in = '0;
               end
            endcase
         end
         ST_ABS: begin
            state_in  = ST_SQ;
            op_cnt_in = '0;
         end
         ST_SQ: begin
            op_cnt_in   = op_cnt_ff + 1'b1;
            tag_in.dest = ACC_DIST;
            unique case (op_cnt_ff)
               4'd0: begin mul_a = MUL_W'(em_ff[0][EM_W-1:HALF_W]);
                  mul_b = MUL_W'(em_ff[0][EM_W-1:HALF_W]); tag_in.sh = SH_HIGH; end
               4'd1: begin mul_a = MUL_W'(em_ff[0][EM_W-1:HALF_W]);
                  mul_b = MUL_W'(em_ff[0][HALF_W-1:0]); tag_in.sh = SH_MID; end
               4'd2: begin mul_a = MUL_W'(em_ff[0][HALF_W-1:0]);
                  mul_b = MUL_W'(em_ff[0][HALF_W-1:0]); tag_in.sh = SH_NONE; end
               4'd3: begin mul_a = MUL_W'(em_ff[1][EM_W-1:HALF_W]);
                  mul_b = MUL_W'(em_ff[1][EM_W-1:HALF_W]); tag_in.sh = SH_HIGH; end
               4'd4: begin mul_a = MUL_W'(em_ff[1][EM_W-1:HALF_W]);
                  mul_b = MUL_W'(em_ff[1][HALF_W-1:0]); tag_in.sh = SH_MID; end
               4'd5: begin mul_a = MUL_W'(em_ff[1][HALF_W-1:0]);
                  mul_b = MUL_W'(em_ff[1][HALF_W-1:0]); tag_in.sh = SH_NONE; end
               4'd6: begin mul_a = MUL_W'(em_ff[2][EM_W-1:HALF_W]);
                  mul_b = MUL_W'(em_ff[2][EM_W-1:HALF_W]); tag_in.sh = SH_HIGH; end
               4'd7: begin mul_a = MUL_W'(em_ff[2][EM_W-1:HALF_W]);
                  mul_b = MUL_W'(em_ff[2][HALF_W-1:0]); tag_in.sh = SH_MID; end
               4'd8: begin mul_a = MUL_W'(em_ff[2][HALF_W-1:0]);
                  mul_b = MUL_W'(em_ff[2][HALF_W-1:0]); tag_in.sh = SH_NONE; end
               default: begin
                  tag_in.dest = ACC_NONE;
                  state_in    = ST_CMP;
                  op_cnt_in   = '0;
               end
            endcase
         end
         ST_CMP: begin
            state_in = last_seg ? ST_IDLE : ST_FETCH;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      unique case (tag_ff.sh)
         SH_NONE: sq_add = DIST_W'(prod_ff[2*HALF_W-1:0]);
         SH_MID:  sq_add = DIST_W'(prod_ff[2*HALF_W-1:0]) << SH_MID_AMT;
         SH_HIGH: sq_add = DIST_W'(prod_ff[2*HALF_W-1:0]) << SH_HIGH_AMT;
         default: sq_add = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_cnt_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_cnt_ff    <= op_cnt_in;
         rsp_valid_ff <= (accept && req_data.kind == KIND_QUERY && n_start < CNT_W'(MIN_WP))
                         || (state_ff == ST_CMP && last_seg);
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.kind == KIND_LOAD) begin
         mem[req_data.slot] <= '{x: req_data.coord_x, y: req_data.coord_y,
                                 z: req_data.coord_z};
      end
      rd_a_ff <= mem[seg_ff];
      rd_b_ff <= mem[SLOT_W'(seg_ff + 1'b1)];
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      tag_ff  <= tag_in;
      if (accept) begin
         p_ff   <= '{x: req_data.coord_x, y: req_data.coord_y, z: req_data.coord_z};
         n_ff   <= n_start;
         seg_ff <= '0;
         rsp_ff <= '{segment_index: '0, fraction: '0, too_few_points: 1'b1};
      end
      unique case (tag_ff.dest)
         ACC_DD:   dd_ff   <= dd_ff + DD_W'(prod_ff);
         ACC_VD:   vd_ff   <= vd_ff + VD_W'(prod_ff);
         ACC_EX:   e_ff[0] <= (E_W'(v_ff[0]) <<< FRAC_W) - E_W'(prod_ff);
         ACC_EY:   e_ff[1] <= (E_W'(v_ff[1]) <<< FRAC_W) - E_W'(prod_ff);
         ACC_EZ:   e_ff[2] <= (E_W'(v_ff[2]) <<< FRAC_W) - E_W'(prod_ff);
         ACC_DIST: dist_ff <= dist_ff + sq_add;
         default: begin
         end
      endcase
      unique case (state_ff)
         ST_DIFF: begin
            d_ff[0] <= D_W'(rd_b_ff.x) - D_W'(rd_a_ff.x);
            d_ff[1] <= D_W'(rd_b_ff.y) - D_W'(rd_a_ff.y);
            d_ff[2] <= D_W'(rd_b_ff.z) - D_W'(rd_a_ff.z);
            v_ff[0] <= D_W'(p_ff.x) - D_W'(rd_a_ff.x);
            v_ff[1] <= D_W'(p_ff.y) - D_W'(rd_a_ff.y);
            v_ff[2] <= D_W'(p_ff.z) - D_W'(rd_a_ff.z);
            dd_ff   <= '0;
            vd_ff   <= '0;
         end
         ST_DIV: begin
            if (op_cnt_ff == '0) begin
               if (zero_t) begin
                  t_ff <= '0;
               end else if (full_t) begin
                  t_ff <= T_ONE;
               end
            end else if (div_tail.valid) begin
               t_ff <= {1'b0, div_tail.quo};
            end
         end
         ST_ABS: begin
            for (int k = 0; k < 3; k++) begin
               em_ff[k] <= e_ff[k][E_W-1] ? EM_W'(-e_ff[k]) : EM_W'(e_ff[k]);
            end
            dist_ff <= '0;
         end
         ST_CMP: begin
            if (take_cur) begin
               best_dist_ff <= dist_ff;
               best_seg_ff  <= seg_ff;
               best_t_ff    <= t_ff;
            end
            seg_ff <= seg_ff + 1'b1;
            rsp_ff <= '{segment_index: take_cur ? seg_ff : best_seg_ff,
                        fraction:      take_cur ? t_ff : best_t_ff,
                        too_few_points: 1'b0};
         end
         default: begin
         end
      endcase
   end

endmodule

// File: src/ppop_checker.sv
// Port-level checks for polyline_progress_of_point_core, bound to the top.
// Depends on ppop_pkg.
module ppop_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input ppop_pkg::req_type req_data,
   input logic              rsp_valid,
   input ppop_pkg::rsp_type rsp_data
);
   import ppop_pkg::*;

   a_too_few_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.too_few_points |->
         rsp_data.segment_index == '0 && rsp_data.fraction == '0)
      else $error("too_few_points result carries nonzero fields");

   a_fraction_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.fraction <= T_ONE)
      else $error("fraction above one");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.kind == KIND_LOAD |=> !rsp_valid)
      else $error("load transaction produced a result");

   a_walk_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.too_few_points |-> $past(busy))
      else $error("segment result without a busy walk");

endmodule

bind polyline_progress_of_point_core ppop_checker u_ppop_checker (.*);

// File: tb/sv/polyline_progress_of_point_core_tb.sv
// Testbench for polyline_progress_of_point_core: loads waypoints, queries points
// and checks each closest-segment result against an exact integer projection.
// Depends on ppop_pkg and the core RTL.
module polyline_progress_of_point_core_tb;
   import ppop_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_we = 1'b0;
   logic [6:0] csr_wdata = '0;

   req_type    pending_items[$];
   rsp_type    expected_progress[$];
   wp_type     polyline_table[MAX_WP];
   wp_type     gen_table[MAX_WP];
   int         waypoint_limit = 0;
   int         error_count = 0;
   bit         no_idle = 1'b0;

   polyline_progress_of_point_core u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic rsp_type project_onto_polyline(req_type q);
      rsp_type r;
      int n;
      longint dx, dy, dz, vx, vy, vz, t, ex, ey, ez;
      logic signed [127:0] dd, vd, seg_dist, best_d;
      r = '0;
      n = (waypoint_limit > MAX_WP) ? MAX_WP : waypoint_limit;
      if (n < MIN_WP) begin
         r.too_few_points = 1'b1;
         return r;
      end
      best_d = '0;
      for (int i = 0; i + 1 < n; i++) begin
         dx = longint'(polyline_table[i+1].x) - longint'(polyline_table[i].x);
         dy = longint'(polyline_table[i+1].y) - longint'(polyline_table[i].y);
         dz = longint'(polyline_table[i+1].z) - longint'(polyline_table[i].z);
         vx = longint'(q.coord_x) - longint'(polyline_table[i].x);
         vy = longint'(q.coord_y) - longint'(polyline_table[i].y);
         vz = longint'(q.coord_z) - longint'(polyline_table[i].z);
         dd = 128'(dx * dx) + 128'(dy * dy) + 128'(dz * dz);
         vd = 128'(vx * dx) + 128'(vy * dy) + 128'(vz * dz);
         if (dd == 0 || vd <= 0) t = 0;
         else if (vd >= dd) t = 64'd1 << FRAC_W;
         else t = longint'((vd <<< FRAC_W) / dd);
         ex = (vx <<< FRAC_W) - t * dx;
         ey = (vy <<< FRAC_W) - t * dy;
         ez = (vz <<< FRAC_W) - t * dz;
         seg_dist = 128'(ex) * 128'(ex) + 128'(ey) * 128'(ey) + 128'(ez) * 128'(ez);
         if (i == 0 || seg_dist < best_d) begin
            best_d = seg_dist;
            r.segment_index = SLOT_W'(i);
            r.fraction = T_W'(t);
         end
      end
      return r;
   endfunction

   // driver: hold start until accepted, then advance
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            if (req_data.kind == KIND_LOAD)
               polyline_table[req_data.slot] <= '{req_data.coord_x, req_data.coord_y,
                                                  req_data.coord_z};
            else
               expected_progress.push_back(project_onto_polyline(req_data));
         end
         if (!start || !busy) begin
            if (pending_items.size() != 0 && (no_idle || $urandom_range(99) >= 19)) begin
               start    <= 1'b1;
               req_data <= pending_items.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_progress.size() == 0) begin
            $error("unexpected transaction %p", rsp_data);
            error_count++;
         end else begin
            e = expected_progress.pop_front();
            if (rsp_data.segment_index !== e.segment_index) begin
               $error("segment_index exp %0d got %0d", e.segment_index,
                      rsp_data.segment_index);
               error_count++;
            end
            if (rsp_data.fraction !== e.fraction) begin
               $error("fraction exp %0d got %0d", e.fraction, rsp_data.fraction);
               error_count++;
            end
            if (rsp_data.too_few_points !== e.too_few_points) begin
               $error("too_few_points exp %0d got %0d", e.too_few_points,
                      rsp_data.too_few_points);
               error_count++;
            end
         end
      end
   end

   function automatic logic signed [COORD_W-1:0] rand_coord();
      case ($urandom_range(9))
         0:       return COORD_W'(-(1 <<< (COORD_W - 1)));
         1:       return COORD_W'((1 <<< (COORD_W - 1)) - 1);
         2, 3:    return COORD_W'($signed($urandom_range(200)) - 100);
         default: return COORD_W'($urandom);
      endcase
   endfunction

   task automatic push_load(int s, logic signed [COORD_W-1:0] x,
                            logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
      gen_table[s] = '{x, y, z};
      pending_items.push_back('{KIND_LOAD, SLOT_W'(s), x, y, z});
   endtask

   task automatic push_query(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                             logic signed [COORD_W-1:0] z);
      pending_items.push_back('{KIND_QUERY, SLOT_W'($urandom), x, y, z});
   endtask

   task automatic wait_idle();
      wait (pending_items.size() == 0 && !start && expected_progress.size() == 0);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_count(int value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= 7'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      waypoint_limit = value;
   endtask

   task automatic random_item(int n);
      int s;
      wp_type w;
      if ($urandom_range(99) < 30) begin
         s = (n >= 2 && $urandom_range(3) != 0) ? $urandom_range(n - 1) : $urandom_range(63);
         if (s > 0 && $urandom_range(9) == 0)
            push_load(s, gen_table[s-1].x, gen_table[s-1].y, gen_table[s-1].z);
         else
            push_load(s, rand_coord(), rand_coord(), rand_coord());
      end else begin
         w = gen_table[$urandom_range((n >= 2) ? n - 1 : 63)];
         case ($urandom_range(3))
            0: push_query(rand_coord(), rand_coord(), rand_coord());
            1: push_query(w.x, w.y, w.z);
            default: push_query(w.x + COORD_W'($signed($urandom_range(2000)) - 1000),
                                w.y + COORD_W'($signed($urandom_range(2000)) - 1000),
                                w.z + COORD_W'($signed($urandom_range(2000)) - 1000));
         endcase
      end
   endtask

   initial begin
      int counts[12] = '{0, 1, 2, 3, 4, 5, 6, 8, 64, 127, 2, 7};
      logic signed [COORD_W-1:0] lo, hi;
      lo = COORD_W'(-(1 <<< (COORD_W - 1)));
      hi = COORD_W'((1 <<< (COORD_W - 1)) - 1);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      push_query(lo, hi, lo);
      for (int s = 0; s < MAX_WP; s++)
         push_load(s, rand_coord(), rand_coord(), rand_coord());
      write_count(1);
      push_query(hi, lo, hi);
      push_load(0, 0, 0, 0);
      push_load(1, 1000, 0, 0);
      push_load(2, 1000, 0, 0);
      push_load(3, hi, hi, hi);
      push_load(4, lo, lo, lo);
      write_count(2);
      push_query(0, 0, 0);
      push_query(-50, 7, 0);
      push_query(2000, 3, 0);
      push_query(333, 100, -100);
      push_query(hi, lo, hi);
      write_count(3);
      push_query(1000, 0, 0);
      push_query(1500, 9, 9);
      write_count(5);
      push_query(hi, hi, hi);
      push_query(lo, lo, lo);
      push_query(0, hi, lo);
      foreach (counts[p]) begin
         write_count(counts[p]);
         no_idle = (p == 3);
         for (int k = 0; k < ((counts[p] > 10) ? 10 : 110); k++)
            random_item(counts[p] > MAX_WP ? MAX_WP : counts[p]);
      end
      wait_idle();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
